// ----- rtl/core/ucl_pkg.sv -----
// Shared types and constants for the up-case table loader.
// No dependencies; imported by every module under rtl/core.
package ucl_pkg;

    localparam int DefaultMapEntries = 256;

    localparam logic [1:0] KIND_RESTART = 2'd0;
    localparam logic [1:0] KIND_FEED    = 2'd1;
    localparam logic [1:0] KIND_LOOKUP  = 2'd2;

    localparam logic [15:0] WORD_RUN_MARK = 16'hFFFF;
    localparam logic [16:0] CHAR_LIMIT    = 17'h10000;

    localparam int InDataWidth  = 24;
    localparam int OutDataWidth = 72;

    typedef struct packed {
        logic [31:0] checksum;
        logic [16:0] cursor;
        logic        error;
    } ucl_status_t;

endpackage

// ----- rtl/core/ucl_map.sv -----
// Mapping memory with registered read and per-entry written bits.
// Depends on ucl_pkg.
module ucl_map #(
    parameter int MAP_ENTRIES = ucl_pkg::DefaultMapEntries,
    parameter int AW          = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data,
    output logic          rd_written
);
    import ucl_pkg::*;

    logic [15:0]            mem [MAP_ENTRIES];
    logic [MAP_ENTRIES-1:0] written_reg;
    logic [15:0]            rd_data_reg;
    logic                   rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                written_reg <= '0;
            end
            else if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data    = rd_data_reg;
    assign rd_written = rd_written_reg;

endmodule

// ----- rtl/core/ucl_parse.sv -----
// Byte parser: checksum, word pairing, run decoding and character cursor.
// Depends on ucl_pkg; drives the write side of ucl_map.
module ucl_parse #(
    parameter int MAP_ENTRIES = ucl_pkg::DefaultMapEntries,
    parameter int AW          = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 restart,
    input  logic                 feed,
    input  logic [7:0]           data_byte,
    output ucl_pkg::ucl_status_t status,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [15:0]          wr_data
);
    import ucl_pkg::*;

    localparam logic [16:0] MapLimit = 17'(MAP_ENTRIES);

    logic [31:0] sum_reg,     sum_next;
    logic [16:0] cursor_reg,  cursor_next;
    logic [7:0]  hold_reg,    hold_next;
    logic        present_reg, present_next;
    logic        count_reg,   count_next;
    logic        error_reg,   error_next;
    logic [15:0] word;
    logic [16:0] room;

    assign word = {data_byte, hold_reg};
    assign room = CHAR_LIMIT - cursor_reg;

    always_comb
    begin
        sum_next     = sum_reg;
        cursor_next  = cursor_reg;
        hold_next    = hold_reg;
        present_next = present_reg;
        count_next   = count_reg;
        error_next   = error_reg;
        wr_en        = 1'b0;
        if (restart)
        begin
            sum_next     = '0;
            cursor_next  = '0;
            hold_next    = '0;
            present_next = 1'b0;
            count_next   = 1'b0;
            error_next   = 1'b0;
        end
        else if (feed)
        begin
            sum_next = {sum_reg[0], sum_reg[31:1]} + {24'd0, data_byte};
            if (!present_reg)
            begin
                hold_next    = data_byte;
                present_next = 1'b1;
            end
            else
            begin
                present_next = 1'b0;
                if (count_reg)
                begin
                    count_next = 1'b0;
                    if ({1'b0, word} > room)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        cursor_next = cursor_reg + {1'b0, word};
                    end
                end
                else if (word == WORD_RUN_MARK)
                begin
                    count_next = 1'b1;
                end
                else if (cursor_reg[16])
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    wr_en       = (cursor_reg < MapLimit);
                    cursor_next = cursor_reg + 17'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            cursor_reg  <= '0;
            hold_reg    <= '0;
            present_reg <= 1'b0;
            count_reg   <= 1'b0;
            error_reg   <= 1'b0;
        end
        else
        begin
            sum_reg     <= sum_next;
            cursor_reg  <= cursor_next;
            hold_reg    <= hold_next;
            present_reg <= present_next;
            count_reg   <= count_next;
            error_reg   <= error_next;
        end
    end

    assign wr_addr         = cursor_reg[AW-1:0];
    assign wr_data         = word;
    assign status.checksum = sum_reg;
    assign status.cursor   = cursor_reg;
    assign status.error    = error_reg;

endmodule

// ----- rtl/core/upcase_table_loader.sv -----
// Top level of the up-case table loader: handshakes, lookup stage, result register.
// Depends on ucl_pkg, ucl_parse and ucl_map.
//
// channel  | signals                       | payload
// ---------+-------------------------------+----------------------------------------
// s_axis   | tvalid tready tdata tuser     | tuser: kind; tdata: data_byte, char_code
// m_axis   | tvalid tready tdata           | tdata: mapped_char, exact, table_checksum,
//          |                               |        chars_defined, malformed
//
// Every item yields one result via the lookup stage and result register; a new item
// is taken each cycle while the result side drains. The lookup stage uses the single
// read port of the map memory. Reset and restart items clear the status registers
// and written bits at once; no clearing pass. A stalled m_axis holds one result
// in the output register and one in the lookup stage, then s_axis_tready drops.
module upcase_table_loader #(
    parameter int MAP_ENTRIES = ucl_pkg::DefaultMapEntries
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ucl_pkg::InDataWidth-1:0]   s_axis_tdata,  // data_byte, char_code
    input  logic [1:0]                        s_axis_tuser,  // kind
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // mapped_char, exact, table_checksum, chars_defined, malformed, zero pad
    output logic [ucl_pkg::OutDataWidth-1:0]  m_axis_tdata
);
    import ucl_pkg::*;

    localparam int          AW       = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam logic [16:0] MapLimit = 17'(MAP_ENTRIES);

    logic              accept;
    logic              restart;
    logic              feed;
    logic              lookup;
    logic [7:0]        in_byte;
    logic [15:0]       in_char;
    ucl_status_t       status;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [15:0]       wr_data;
    logic [15:0]       rd_data;
    logic              rd_written;
    logic              in_range;

    logic              s1_valid_reg,  s1_valid_next;
    logic              s1_lookup_reg;
    logic              s1_exact_reg;
    logic [15:0]       s1_char_reg;
    logic              s1_move;
    logic              out_valid_reg, out_valid_next;
    logic [OutDataWidth-1:0] out_data_reg;
    logic [15:0]       mapped;
    logic              exact;

    assign in_byte = s_axis_tdata[7:0];
    assign in_char = s_axis_tdata[23:8];
    assign s1_move = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign restart = accept && (s_axis_tuser == KIND_RESTART);
    assign feed    = accept && (s_axis_tuser == KIND_FEED);
    assign lookup  = accept && (s_axis_tuser == KIND_LOOKUP);
    assign in_range = ({1'b0, in_char} < MapLimit) && ({1'b0, in_char} < status.cursor);

    ucl_parse #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .AW          (AW)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .feed      (feed),
        .data_byte (in_byte),
        .status    (status),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    ucl_map #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .AW          (AW)
    ) u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (restart),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (lookup),
        .rd_addr    (in_char[AW-1:0]),
        .rd_data    (rd_data),
        .rd_written (rd_written)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        mapped = '0;
        exact  = 1'b0;
        if (s1_lookup_reg)
        begin
            exact  = s1_exact_reg;
            mapped = (s1_exact_reg && rd_written) ? rd_data : s1_char_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_lookup_reg <= (s_axis_tuser == KIND_LOOKUP);
            s1_exact_reg  <= in_range;
            s1_char_reg   <= in_char;
        end
        if (s1_move)
        begin
            out_data_reg <= {5'd0, status.error, status.cursor, status.checksum,
                             exact, mapped};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
